[rtl/core/psd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Types, constants and the per-word packet step shared by the sample deframer.
// ----------------------------------------------------------------------------
package psd_pkg;

  // packet limits
  localparam int SubrunCount     = 256;
  localparam int AsicCount       = 8;
  localparam int ChannelsPerAsic = 16;
  localparam int DataStartOffset = 16;

  // delay line depth and most results one word can cause
  localparam int DelayDepth = 4;
  localparam int MaxResults = DelayDepth + 1;
  localparam int CountW     = $clog2(MaxResults + 1);

  // header words
  localparam logic [15:0] HdrZero = 16'h0000;
  localparam logic [15:0] HdrDead = 16'hdead;
  localparam logic [15:0] HdrBeef = 16'hbeef;
  localparam logic [15:0] HdrBase = 16'hba5e;

  // fixed packet offsets
  localparam logic [4:0] OffSubrun = 5'd5;
  localparam logic [4:0] OffAsic   = 5'd6;
  localparam logic [4:0] OffAsicCh = 5'd7;
  localparam logic [4:0] OffMax    = 5'd31;

  // output word width: 27 payload bits padded to bytes
  localparam int OutDataW = 32;

  typedef struct packed {
    logic [4:0] off;
    logic       acc;
    logic [7:0] subrun;
    logic [2:0] asic;
    logic [3:0] asic_ch;
  } pkt_state_t;

  typedef struct packed {
    logic        last;
    logic [11:0] sample;
    logic [6:0]  channel;
    logic [7:0]  subrun;
  } result_t;

  typedef struct packed {
    pkt_state_t st;
    logic       hit;
    result_t    res;
  } take_t;

  // results of one word, packed to the low slots
  typedef struct packed {
    logic [CountW-1:0]             count;
    result_t [MaxResults-1:0]      res;
  } res_bundle_t;

  // one word through the open packet
  function automatic take_t take_word(pkt_state_t st, logic en, logic [15:0] w);
    take_t t;
    t.st          = st;
    t.hit         = 1'b0;
    t.res.last    = 1'b0;
    t.res.sample  = w[11:0];
    t.res.channel = {st.asic, st.asic_ch};
    t.res.subrun  = st.subrun;
    if (en) begin
      case (st.off)
        OffSubrun: begin
          if (32'(w) >= SubrunCount) t.st.acc = 1'b0;
          t.st.subrun = w[7:0];
        end
        OffAsic: begin
          if ((32'(w) >= AsicCount) || (w >= 16'd8)) t.st.acc = 1'b0;
          t.st.asic = w[2:0];
        end
        OffAsicCh: begin
          if (32'(w) >= ChannelsPerAsic) t.st.acc = 1'b0;
          t.st.asic_ch = w[3:0];
        end
        default: begin
          if ((st.off >= 5'(DataStartOffset)) && st.acc && (w[15:12] == st.asic_ch)) begin
            t.hit = 1'b1;
          end
        end
      endcase
      if (st.off < OffMax) t.st.off = st.off + 5'd1;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/core/psd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_core
// Header search, four-word delay line, packet field capture and sample
// selection for one word per cycle while step_i is high.
// ----------------------------------------------------------------------------
module psd_core import psd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,     // take the word below this cycle
  input  wire logic [15:0] word_i,
  input  wire logic        eos_i,
  output res_bundle_t      bundle_o
);

  logic [15:0] dly_word_q [DelayDepth];
  logic [15:0] dly_word_d [DelayDepth];
  logic        dly_valid_q [DelayDepth];
  logic        dly_valid_d [DelayDepth];
  logic        in_pkt_q, in_pkt_d;
  pkt_state_t  pkt_q, pkt_d;

  logic        header;
  take_t       tk [MaxResults];

  // header seen in the delay line plus the arriving word
  always_comb begin
    header = dly_valid_q[0] && dly_valid_q[1] && dly_valid_q[2] && dly_valid_q[3] &&
             (dly_word_q[0] == HdrZero) && (dly_word_q[1] == HdrDead) &&
             (dly_word_q[2] == HdrBeef) && (dly_word_q[3] == HdrZero) &&
             (word_i == HdrBase) && !eos_i;
  end

  // shifted delay line, popped word then flushed words on end of stream
  always_comb begin
    for (int i = 0; i < DelayDepth - 1; i++) begin
      dly_word_d[i]  = dly_word_q[i+1];
      dly_valid_d[i] = dly_valid_q[i+1];
    end
    dly_word_d[DelayDepth-1]  = word_i;
    dly_valid_d[DelayDepth-1] = 1'b1;

    tk[0] = take_word(pkt_q, in_pkt_q && dly_valid_q[0], dly_word_q[0]);
    for (int i = 1; i < MaxResults; i++) begin
      tk[i] = take_word(tk[i-1].st, in_pkt_q && eos_i && dly_valid_d[i-1],
                        dly_word_d[i-1]);
    end

    in_pkt_d = in_pkt_q;
    pkt_d    = tk[MaxResults-1].st;
    if (eos_i) begin
      for (int i = 0; i < DelayDepth; i++) dly_valid_d[i] = 1'b0;
    end

    // header opens a new packet and swallows the header words
    if (header) begin
      for (int i = 0; i < DelayDepth; i++) begin
        dly_word_d[i]  = dly_word_q[i];
        dly_valid_d[i] = 1'b0;
      end
      in_pkt_d   = 1'b1;
      pkt_d      = pkt_q;
      pkt_d.off  = OffSubrun;
      pkt_d.acc  = 1'b1;
    end
  end

  // pack the hits into the low result slots
  always_comb begin
    logic [CountW-1:0] idx;
    idx = '0;
    bundle_o.res = '0;
    for (int i = 0; i < MaxResults; i++) begin
      if (tk[i].hit && !header) begin
        bundle_o.res[idx] = tk[i].res;
        idx = idx + CountW'(1);
      end
    end
    if (idx != '0) bundle_o.res[idx - CountW'(1)].last = 1'b1;
    bundle_o.count = idx;
  end

  // packet and delay line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DelayDepth; i++) begin
        dly_word_q[i]  <= '0;
        dly_valid_q[i] <= 1'b0;
      end
      in_pkt_q <= 1'b0;
      pkt_q    <= '0;
    end else if (step_i) begin
      for (int i = 0; i < DelayDepth; i++) begin
        dly_word_q[i]  <= dly_word_d[i];
        dly_valid_q[i] <= dly_valid_d[i];
      end
      in_pkt_q <= in_pkt_d;
      pkt_q    <= pkt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/psd_outbuf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_outbuf
// Result register bank: loads all results of one word at once and hands
// them out one word per handshake.
// ----------------------------------------------------------------------------
module psd_outbuf import psd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire res_bundle_t bundle_i,
  output logic             free_o,     // bank can load this cycle
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output result_t          m_res_o
);

  result_t           slot_q [MaxResults];
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] head_q, head_d;
  logic              take;

  // handshake and free flag
  always_comb begin
    m_valid_o = (head_q != cnt_q);
    take      = m_valid_o && m_ready_i;
    free_o    = !m_valid_o || (take && ((head_q + CountW'(1)) == cnt_q));
    m_res_o   = '0;
    for (int i = 0; i < MaxResults; i++) begin
      if (head_q == CountW'(i)) m_res_o = slot_q[i];
    end
  end

  // pointer update
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = bundle_i.count;
      head_d = '0;
    end else if (take) begin
      head_d = head_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxResults; i++) slot_q[i] <= bundle_i.res[i];
    end
  end

endmodule
`default_nettype wire

[rtl/core/asic_packet_sample_deframer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asic_packet_sample_deframer_top
// Packet sample deframer: finds packet headers in a 16-bit word stream and
// emits the selected 12-bit samples with their subrun and global channel.
// ----------------------------------------------------------------------------
// Usage
//   Slave side: one stream word per handshake, tdata = data word, tlast =
//   end of stream (flushes the four-word delay line after this word).
//   Master side: one result per handshake, tdata = subrun, channel, sample;
//   tlast marks the last result caused by one input word.
//   An input word sits in the input register until the result bank is free,
//   then is processed combinationally into the bank; its first result is
//   offered in the cycle after that. Throughput is one input word per cycle
//   while each word causes at most one result and the receiver is ready; a
//   word that causes k results (up to five on end of stream) holds the input
//   side until the single output port has taken all k results.
//   When the receiver stalls, the input register still takes one word and
//   then tready drops until the bank drains.
//   Reset clears the delay line, the packet state and both buffers; words
//   before the first header give no results.
// ----------------------------------------------------------------------------
module asic_packet_sample_deframer_top import psd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire logic [15:0]         s_tdata_i,   // [15:0] data_word
  input  wire logic                s_tlast_i,   // end_of_stream
  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  output logic [OutDataW-1:0]      m_tdata_o,   // [7:0] subrun, [14:8] channel,
                                                // [26:15] sample, [31:27] zero
  output logic                     m_tlast_o    // last_of_run
);

  logic        in_valid_q;
  logic [15:0] in_word_q;
  logic        in_eos_q;
  logic        out_free;
  logic        process;
  res_bundle_t bundle;
  result_t     out_res;

  assign process    = in_valid_q && out_free;
  assign s_tready_o = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tvalid_i && s_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_word_q <= s_tdata_i;
      in_eos_q  <= s_tlast_i;
    end
  end

  psd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (process),
    .word_i  (in_word_q),
    .eos_i   (in_eos_q),
    .bundle_o(bundle)
  );

  psd_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (process),
    .bundle_i (bundle),
    .free_o   (out_free),
    .m_valid_o(m_tvalid_o),
    .m_ready_i(m_tready_i),
    .m_res_o  (out_res)
  );

  // output word packing
  assign m_tdata_o = {5'd0, out_res.sample, out_res.channel, out_res.subrun};
  assign m_tlast_o = out_res.last;

  // a held input word is not lost while the bank is busy
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("input word dropped while result bank busy");

  // one word never causes more results than the bank holds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |-> (bundle.count <= CountW'(MaxResults)))
    else $error("result count out of range");

  // results of one word come out without a gap
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |=> m_tvalid_o)
    else $error("gap inside a run of results");

endmodule
`default_nettype wire

[verif/psd_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sample_checker
// Watches both streams of the sample deframer. It predicts the expected
// samples from every accepted input word and compares each accepted result
// with the oldest expectation.
// ----------------------------------------------------------------------------
module psd_sample_checker import psd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_tready_i,
  input  wire logic [15:0]         s_tdata_i,   // [15:0] data_word
  input  wire logic                s_tlast_i,   // end_of_stream
  input  wire logic                m_tvalid_i,
  input  wire logic                m_tready_i,
  input  wire logic [OutDataW-1:0] m_tdata_i,   // [7:0] subrun, [14:8] channel,
                                                // [26:15] sample, [31:27] zero
  input  wire logic                m_tlast_i,   // last_of_run
  output int                       pending_o,
  output int                       fail_count_o
);

  // packet limits of this build
  localparam int unsigned SubrunLimit = 256;
  localparam int unsigned AsicLimit   = 8;
  localparam int unsigned ChanLimit   = 16;
  localparam logic [4:0]  FirstData   = 5'd16;
  localparam logic [4:0]  OffsetTop   = 5'd31;
  localparam logic [4:0]  SubrunPos   = 5'd5;
  localparam logic [4:0]  AsicPos     = 5'd6;
  localparam logic [4:0]  ChanPos     = 5'd7;

  // sync pattern
  localparam logic [15:0] SyncZero = 16'h0000;
  localparam logic [15:0] SyncDead = 16'hdead;
  localparam logic [15:0] SyncBeef = 16'hbeef;
  localparam logic [15:0] SyncBase = 16'hba5e;

  typedef struct packed {
    logic [7:0]  subrun;
    logic [6:0]  channel;
    logic [11:0] sample;
    logic        last;
  } sample_rec_t;

  sample_rec_t sample_q[$];
  int          fails;

  // predicted deframer state
  logic [15:0] hold_word [4];
  logic        hold_vld  [4];
  logic        pkt_open;
  logic [4:0]  pkt_off;
  logic [7:0]  pkt_subrun;
  logic [2:0]  pkt_asic;
  logic [3:0]  pkt_chan;
  logic        pkt_ok;

  // one word leaving the delay line into the open packet
  task automatic absorb_word(input logic [15:0] w);
    sample_rec_t rec;
    if (pkt_open) begin
      case (pkt_off)
        SubrunPos: begin
          if (w >= SubrunLimit) pkt_ok = 1'b0;
          pkt_subrun = w[7:0];
        end
        AsicPos: begin
          if (w >= AsicLimit) pkt_ok = 1'b0;
          pkt_asic = w[2:0];
        end
        ChanPos: begin
          if (w >= ChanLimit) pkt_ok = 1'b0;
          pkt_chan = w[3:0];
        end
        default: begin
          if (pkt_off >= FirstData && pkt_ok && w[15:12] == pkt_chan) begin
            rec.subrun  = pkt_subrun;
            rec.channel = {pkt_asic, pkt_chan};
            rec.sample  = w[11:0];
            rec.last    = 1'b0;
            sample_q    = {sample_q, rec};
          end
        end
      endcase
      if (pkt_off < OffsetTop) pkt_off = pkt_off + 5'd1;
    end
  endtask

  // one accepted stream word: header search, delay line and flush
  task automatic deframe_word(input logic [15:0] w, input logic eos);
    int   n0;
    logic sync_hit;
    logic pop_vld;
    logic [15:0] pop_word;
    n0 = sample_q.size();
    sync_hit = hold_vld[0] && hold_vld[1] && hold_vld[2] && hold_vld[3] &&
               hold_word[0] == SyncZero && hold_word[1] == SyncDead &&
               hold_word[2] == SyncBeef && hold_word[3] == SyncZero &&
               w == SyncBase && !eos;
    if (sync_hit) begin
      for (int i = 0; i < 4; i++) hold_vld[i] = 1'b0;
      pkt_open = 1'b1;
      pkt_off  = SubrunPos;
      pkt_ok   = 1'b1;
    end else begin
      pop_vld  = hold_vld[0];
      pop_word = hold_word[0];
      for (int i = 0; i < 3; i++) begin
        hold_word[i] = hold_word[i+1];
        hold_vld[i]  = hold_vld[i+1];
      end
      hold_word[3] = w;
      hold_vld[3]  = 1'b1;
      if (pop_vld) absorb_word(pop_word);
      // end of stream pushes out the whole delay line
      if (eos) begin
        for (int i = 0; i < 4; i++) begin
          if (hold_vld[i]) absorb_word(hold_word[i]);
          hold_vld[i] = 1'b0;
        end
      end
    end
    if (sample_q.size() > n0) sample_q[sample_q.size()-1].last = 1'b1;
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_result(input logic [OutDataW-1:0] d, input logic l);
    sample_rec_t got;
    sample_rec_t want;
    got.subrun  = d[7:0];
    got.channel = d[14:8];
    got.sample  = d[26:15];
    got.last    = l;
    if (sample_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result: subrun %0d channel %0d sample 0x%03h last %0b",
                 got.subrun, got.channel, got.sample, got.last);
    end else begin
      want = sample_q.pop_front();
      if (got.subrun !== want.subrun || got.channel !== want.channel ||
          got.sample !== want.sample || got.last !== want.last) begin
        fails++;
        if (fails <= 10)
          $display({"result mismatch: expected subrun %0d channel %0d sample 0x%03h ",
                    "last %0b, got subrun %0d channel %0d sample 0x%03h last %0b"},
                   want.subrun, want.channel, want.sample, want.last,
                   got.subrun, got.channel, got.sample, got.last);
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hold_word[i] = '0;
        hold_vld[i]  = 1'b0;
      end
      pkt_open   = 1'b0;
      pkt_off    = '0;
      pkt_subrun = '0;
      pkt_asic   = '0;
      pkt_chan   = '0;
      pkt_ok     = 1'b0;
      sample_q.delete();
      fails         = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i, m_tlast_i);
      if (s_tvalid_i && s_tready_i) deframe_word(s_tdata_i, s_tlast_i);
      pending_o    <= sample_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the packet sample deframer: drives directed and random
// packets, noise and end-of-stream flushes with random gaps on both sides,
// and gives the verdict from the checker's failure count and a stall watchdog.
// ----------------------------------------------------------------------------
module tb import psd_pkg::*;;

  localparam int StallLimit = 2000;
  localparam int RandomWords = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;   // [15:0] data_word
  logic                s_tlast;   // end_of_stream
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // [7:0] subrun, [14:8] channel, [26:15] sample
  logic                m_tlast;   // last_of_run

  int          pending;
  int          fail_count;
  int unsigned stall_cycles = 0;
  int          words_sent;
  bit          tx_quiet;
  bit          rx_quiet;

  asic_packet_sample_deframer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast)
  );

  psd_sample_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one word on the slave side, held until accepted
  task automatic send_word(input logic [15:0] w, input logic eos);
    int gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = w;
    s_tlast  = eos;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // sync pattern, optionally with end of stream on its last word
  task automatic send_header(input logic eos);
    send_word(16'h0000, 1'b0);
    send_word(16'hdead, 1'b0);
    send_word(16'hbeef, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hba5e, eos);
  endtask

  // header, three id words, then body words from offset 8 on
  task automatic send_packet(input logic [15:0] sub_w, input logic [15:0] asic_w,
                             input logic [15:0] ch_w, input int body, input bit eos_end);
    logic [15:0] words[$];
    logic [15:0] w;
    words = {sub_w, asic_w, ch_w};
    for (int i = 0; i < body; i++) begin
      // most data words carry the packet channel in the top nibble
      if (i >= 8 && $urandom_range(0, 3) != 0) w = {ch_w[3:0], 12'($urandom)};
      else w = 16'($urandom);
      words = {words, w};
    end
    send_header(1'b0);
    foreach (words[i]) send_word(words[i], eos_end && (i == words.size() - 1));
  endtask

  // hold the sender until every expected sample has come out
  task automatic wait_samples_out();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: ready bursts with random stalls
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = pick_gap(rx_quiet);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    int start_words;
    int seq;
    int kind;
    int which;
    bit eos_end;
    logic [15:0] sub_w;
    logic [15:0] asic_w;
    logic [15:0] ch_w;
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    words_sent   = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // words ahead of any header are dropped
    send_word(16'hffff, 1'b0);
    send_word(16'h0000, 1'b0);
    // top ids, ignored filler, data with both nibble outcomes
    send_header(1'b0);
    send_word(16'h00ff, 1'b0);
    send_word(16'h0007, 1'b0);
    send_word(16'h000f, 1'b0);
    repeat (8) send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'hf000, 1'b0);
    send_word(16'h7abc, 1'b0);
    // sync pattern ending on the final word is flushed as data
    send_header(1'b1);
    wait_samples_out();

    // random packets, noise and flushes
    start_words = words_sent;
    seq = 0;
    while (words_sent - start_words < RandomWords) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      kind     = $urandom_range(0, 99);
      eos_end  = ($urandom_range(0, 5) == 0);
      sub_w    = 16'($urandom_range(0, 255));
      asic_w   = 16'($urandom_range(0, 7));
      ch_w     = 16'($urandom_range(0, 15));
      if (kind < 55) begin
        send_packet(sub_w, asic_w, ch_w, $urandom_range(8, 20), eos_end);
      end else if (kind < 63) begin
        // long packet, the offset counter saturates when the body runs past offset 31
        send_packet(sub_w, asic_w, ch_w, $urandom_range(22, 32), eos_end);
      end else if (kind < 73) begin
        // one id out of range drops the whole packet
        which  = $urandom_range(0, 2);
        if (which == 0) sub_w = 16'($urandom_range(256, 65535));
        else if (which == 1) asic_w = 16'($urandom_range(8, 65535));
        else ch_w = 16'($urandom_range(16, 65535));
        send_packet(sub_w, asic_w, ch_w, $urandom_range(8, 14), eos_end);
      end else if (kind < 81) begin
        // packet cut short before the data offset
        send_packet(sub_w, asic_w, ch_w, $urandom_range(0, 7), eos_end);
      end else if (kind < 87) begin
        send_header(1'b1);
      end else if (kind < 93) begin
        // broken sync pattern
        send_word(16'h0000, 1'b0);
        send_word(16'hdead, 1'b0);
        send_word(16'hbeef, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hba5f, eos_end);
      end else begin
        repeat ($urandom_range(1, 4)) send_word(16'($urandom), ($urandom_range(0, 7) == 0));
      end
      seq++;
      if (seq % 5 == 0) wait_samples_out();
    end

    // drain and verdict
    tx_quiet = 1'b0;
    wait_samples_out();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
